// ===== sv/phl_pkg.sv =====
// Shared constants, types and codes of the pixelwise hinge loss block.
`timescale 1ns / 1ps
package phl_pkg;

  localparam int MAX_CLASSES   = 256;
  localparam int SCORE_BITS    = 16;
  localparam int LABEL_BITS    = 10;
  localparam int CH_BITS       = 8;
  localparam int NCH_BITS      = 9;
  localparam int HINGE_BITS    = 16;
  localparam int GRAD_BITS     = 18;
  localparam int SQ_BITS       = 2 * HINGE_BITS;
  localparam int SUM_BITS      = 48;
  localparam int CNT_BITS      = 32;
  localparam int ONE_Q8        = 256;
  localparam int QDEPTH        = 4;
  localparam int QPTR_BITS     = 2;
  localparam int DIV_STEPS     = SUM_BITS;
  localparam int DIV_CNT_BITS  = 6;
  localparam int IN_DATA_BITS  = 32;
  localparam int OUT_DATA_BITS = 152;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [NCH_BITS-1:0] NUM_CHANNELS_RESET = 9'd32;

  // Result kinds
  localparam logic KIND_ELEM    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Loss norms
  localparam logic MODE_L1 = 1'b0;
  localparam logic MODE_L2 = 1'b1;

  // Register indexes (word address bit 2)
  localparam logic REG_IDX_NUM_CHANNELS = 1'b0;
  localparam logic REG_IDX_NORM_MODE    = 1'b1;

  // Classified element passed from the front end to the back end
  typedef struct packed {
    logic [HINGE_BITS-1:0] hinge;
    logic                  is_label;
    logic                  lbl_ok;
    logic                  close_valid;
    logic                  close_correct;
    logic                  eob;
  } phl_elem_t;

  typedef struct packed {
    logic                start;
    logic [SUM_BITS-1:0] dividend;
    logic [CNT_BITS-1:0] divisor;
  } phl_div_req_t;

  typedef struct packed {
    logic                done;
    logic [SUM_BITS-1:0] quotient;
  } phl_div_rsp_t;

endpackage

// ===== sv/phl_front.sv =====
// Front end: accepts score requests, tracks the argmax and classifies each element.
`timescale 1ns / 1ps
module phl_front import phl_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [SCORE_BITS-1:0] score,
  input  logic [LABEL_BITS-1:0]        class_label,
  input  logic                         last_channel,
  input  logic                         end_of_batch,
  input  logic [NCH_BITS-1:0]          num_channels,
  input  logic                         q_full,
  output logic                         q_push,
  output phl_elem_t                    q_elem
);

  logic [CH_BITS-1:0]           ch_r, ch_nxt;
  logic signed [SCORE_BITS-1:0] max_r, max_nxt;
  logic [CH_BITS-1:0]           cls_r, cls_nxt;

  logic [NCH_BITS-1:0]          chans;
  logic                         lbl_ok;
  logic                         is_label;
  logic signed [SCORE_BITS:0]   score_x;
  logic signed [SCORE_BITS:0]   sv;
  logic signed [SCORE_BITS+1:0] hv;
  logic                         upd;
  logic [CH_BITS-1:0]           new_cls;
  logic                         close_px;
  logic                         accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  // Clamp the class count and test the label against it
  always_comb begin
    chans    = (num_channels > NCH_BITS'(MAX_CLASSES)) ? NCH_BITS'(MAX_CLASSES) : num_channels;
    lbl_ok   = !class_label[LABEL_BITS-1] && (class_label[NCH_BITS-1:0] < chans);
    is_label = class_label[NCH_BITS-1:0] == {1'b0, ch_r};
  end

  // Hinge of the element, with the label score negated
  always_comb begin
    score_x = {score[SCORE_BITS-1], score};
    sv      = is_label ? -score_x : score_x;
    hv      = (SCORE_BITS+2)'(sv) + (SCORE_BITS+2)'(ONE_Q8);
  end

  // First maximum of the pixel; the first channel always loads it
  always_comb begin
    upd      = (ch_r == '0) || (score > max_r);
    new_cls  = upd ? ch_r : cls_r;
    close_px = last_channel || end_of_batch;
    max_nxt  = max_r;
    cls_nxt  = cls_r;
    ch_nxt   = ch_r;
    if (accept) begin
      max_nxt = upd ? score : max_r;
      cls_nxt = new_cls;
      ch_nxt  = close_px ? '0 : ch_r + 1'b1;
    end
  end

  always_comb begin
    q_push               = accept;
    q_elem.hinge         = (!lbl_ok || hv[SCORE_BITS+1]) ? '0 : hv[HINGE_BITS-1:0];
    q_elem.is_label      = is_label;
    q_elem.lbl_ok        = lbl_ok;
    q_elem.close_valid   = close_px && lbl_ok;
    q_elem.close_correct = close_px && lbl_ok &&
                           ({1'b0, new_cls} == class_label[NCH_BITS-1:0]);
    q_elem.eob           = end_of_batch;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r  <= '0;
      max_r <= '0;
      cls_r <= '0;
    end else begin
      ch_r  <= ch_nxt;
      max_r <= max_nxt;
      cls_r <= cls_nxt;
    end
  end

endmodule

// ===== sv/phl_fifo.sv =====
// Short queue of classified elements between the front and back ends.
`timescale 1ns / 1ps
module phl_fifo import phl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  phl_elem_t din,
  output logic      full,
  input  logic      pop,
  output phl_elem_t dout,
  output logic      empty
);

  phl_elem_t            slots_r [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_BITS:0]   count_r, count_nxt;

  assign full  = count_r == (QPTR_BITS+1)'(QDEPTH);
  assign empty = count_r == '0;
  assign dout  = slots_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  // Store the entry at the write pointer
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== sv/phl_div.sv =====
// Restoring divider for the batch mean: one quotient bit per cycle.
`timescale 1ns / 1ps
module phl_div import phl_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  phl_div_req_t req,
  output phl_div_rsp_t rsp
);

  logic                    busy_r;
  logic                    done_r;
  logic [DIV_CNT_BITS-1:0] cnt_r;
  logic [SUM_BITS-1:0]     dq_r;
  logic [CNT_BITS-1:0]     rem_r;
  logic [CNT_BITS-1:0]     dsr_r;

  logic [CNT_BITS:0]       trial;
  logic [CNT_BITS:0]       diff;
  logic                    ge;

  // Shift in the next dividend bit and subtract where the divisor fits
  always_comb begin
    trial = {rem_r, dq_r[SUM_BITS-1]};
    diff  = trial - {1'b0, dsr_r};
    ge    = trial >= {1'b0, dsr_r};
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dq_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      dq_r  <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      dq_r  <= {dq_r[SUM_BITS-2:0], ge};
      rem_r <= ge ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !req.start && (cnt_r == DIV_CNT_BITS'(DIV_STEPS - 1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== sv/phl_back.sv =====
// Back end: squares, gradients, batch accumulators, summary and output register.
`timescale 1ns / 1ps
module phl_back import phl_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        norm_mode,
  input  logic                        q_empty,
  input  phl_elem_t                   q_elem,
  output logic                        q_pop,
  output phl_div_req_t                div_req,
  input  phl_div_rsp_t                div_rsp,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        result_kind,
  output logic [HINGE_BITS-1:0]       hinge_value,
  output logic signed [GRAD_BITS-1:0] gradient_value,
  output logic [SUM_BITS-1:0]         mean_loss,
  output logic [CNT_BITS-1:0]         valid_pixels,
  output logic [CNT_BITS-1:0]         correct_pixels,
  output logic                        last
);

  typedef enum logic [1:0] {ST_RUN, ST_DIV, ST_SUM} state_t;

  state_t              state_r;

  // Square stage
  logic                s1_valid_r;
  phl_elem_t           s1_elem_r;
  logic [SQ_BITS-1:0]  s1_sq_r;

  // Batch accumulators
  logic [SUM_BITS-1:0] loss_r;
  logic [CNT_BITS-1:0] vcnt_r;
  logic [CNT_BITS-1:0] ccnt_r;
  logic [SUM_BITS-1:0] quot_r;

  // Output register
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic                  kind_r;
  logic [HINGE_BITS-1:0] hinge_r;
  logic [GRAD_BITS-1:0]  grad_r;
  logic [SUM_BITS-1:0]   mean_r;
  logic [CNT_BITS-1:0]   vout_r;
  logic [CNT_BITS-1:0]   cout_r;
  logic                  last_r;

  logic                  out_free;
  logic                  s2_fire;
  logic                  s1_take;
  logic [SUM_BITS-1:0]   add_val;
  logic [SUM_BITS:0]     sum_ext;
  logic [SUM_BITS-1:0]   loss_nxt;
  logic [CNT_BITS-1:0]   vcnt_nxt;
  logic [CNT_BITS-1:0]   ccnt_nxt;
  logic [GRAD_BITS-1:0]  mag;
  logic [GRAD_BITS-1:0]  grad_val;

  assign out_free = !out_valid_r || out_ready;
  assign s2_fire  = s1_valid_r && (state_r == ST_RUN) && out_free;
  assign s1_take  = !s1_valid_r || s2_fire;
  assign q_pop    = !q_empty && s1_take;

  // Loss increment, saturating sum and counts
  always_comb begin
    add_val  = (norm_mode == MODE_L2) ? SUM_BITS'(s1_sq_r) : SUM_BITS'(s1_elem_r.hinge);
    sum_ext  = {1'b0, loss_r} + {1'b0, add_val};
    loss_nxt = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
    vcnt_nxt = (s1_elem_r.close_valid && vcnt_r != '1) ? vcnt_r + 1'b1 : vcnt_r;
    ccnt_nxt = (s1_elem_r.close_correct && ccnt_r != '1) ? ccnt_r + 1'b1 : ccnt_r;
  end

  // Gradient: unit step in L1, twice the hinge in L2, negated on the label channel, zero on a masked label
  always_comb begin
    if (norm_mode == MODE_L2) begin
      mag = {1'b0, s1_elem_r.hinge, 1'b0};
    end else begin
      mag = (s1_elem_r.hinge != '0) ? GRAD_BITS'(ONE_Q8) : '0;
    end
    if (!s1_elem_r.lbl_ok) begin
      grad_val = '0;
    end else if (s1_elem_r.is_label) begin
      grad_val = GRAD_BITS'(0) - mag;
    end else begin
      grad_val = mag;
    end
  end

  always_comb begin
    div_req.start    = s2_fire && s1_elem_r.eob;
    div_req.dividend = loss_nxt;
    div_req.divisor  = vcnt_nxt;
  end

  // Raise valid on a new result, drop it once the result is taken
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (s2_fire || (state_r == ST_SUM && out_free)) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Square stage: take the queue head and register its square
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_elem_r <= q_elem;
      s1_sq_r   <= q_elem.hinge * q_elem.hinge;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_take) begin
      s1_valid_r <= !q_empty;
    end
  end

  // State, accumulators and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      out_valid_r <= 1'b0;
      loss_r      <= '0;
      vcnt_r      <= '0;
      ccnt_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        ST_RUN: begin
          if (s2_fire) begin
            loss_r      <= loss_nxt;
            vcnt_r      <= vcnt_nxt;
            ccnt_r      <= ccnt_nxt;
            kind_r      <= KIND_ELEM;
            hinge_r     <= s1_elem_r.hinge;
            grad_r      <= grad_val;
            mean_r      <= '0;
            vout_r      <= '0;
            cout_r      <= '0;
            last_r      <= !s1_elem_r.eob;
            if (s1_elem_r.eob) begin
              state_r <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            quot_r  <= div_rsp.quotient;
            state_r <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (out_free) begin
            kind_r      <= KIND_SUMMARY;
            hinge_r     <= '0;
            grad_r      <= '0;
            mean_r      <= (vcnt_r == '0) ? '0 : quot_r;
            vout_r      <= vcnt_r;
            cout_r      <= ccnt_r;
            last_r      <= 1'b1;
            loss_r      <= '0;
            vcnt_r      <= '0;
            ccnt_r      <= '0;
            state_r     <= ST_RUN;
          end
        end
        default: begin
          state_r <= ST_RUN;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign result_kind    = kind_r;
  assign hinge_value    = hinge_r;
  assign gradient_value = grad_r;
  assign mean_loss      = mean_r;
  assign valid_pixels   = vout_r;
  assign correct_pixels = cout_r;
  assign last           = last_r;

endmodule

// ===== sv/pixelwise_hinge_loss.sv =====
// Top level of the pixelwise hinge loss block: ports, configuration and wiring.
`timescale 1ns / 1ps
// Takes one channel score per request, all channels of a pixel in a row, and
// returns one result per element, registered through the queue, the square
// stage and the output register; one element per cycle sustained while the
// output is ready and no batch summary is pending. The element that ends a
// batch gives a second result, the batch summary, after the restoring divide
// of the loss sum by the valid pixel count; the divider produces one quotient
// bit per cycle and input is queued (four entries) while it runs, so the next
// element result waits for the summary. Labels outside the active class range
// mask the pixel. Write num_channels and norm_mode only while the block is idle.
module pixelwise_hinge_loss import phl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // [15:0] score, [25:16] class_label, [31:26] zero
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  input  logic                     in_tlast,   // last_channel
  input  logic                     in_tuser,   // end_of_batch
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // [15:0] hinge_value, [33:16] gradient_value, [81:34] mean_loss,
  // [113:82] valid_pixels, [145:114] correct_pixels, [151:146] zero
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  output logic                     out_tlast,  // last
  output logic                     out_tuser,  // result_kind
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  logic [NCH_BITS-1:0]         num_channels_r;
  logic                        norm_mode_r;
  logic                        cfg_wr;

  logic                        q_full;
  logic                        q_push;
  logic                        q_pop;
  logic                        q_empty;
  phl_elem_t                   q_in;
  phl_elem_t                   q_out;
  phl_div_req_t                div_req;
  phl_div_rsp_t                div_rsp;

  logic                        result_kind;
  logic [HINGE_BITS-1:0]       hinge_value;
  logic signed [GRAD_BITS-1:0] gradient_value;
  logic [SUM_BITS-1:0]         mean_loss;
  logic [CNT_BITS-1:0]         valid_pixels;
  logic [CNT_BITS-1:0]         correct_pixels;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_channels_r <= NUM_CHANNELS_RESET;
      norm_mode_r    <= MODE_L1;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_IDX_NUM_CHANNELS: num_channels_r <= cfg_pwdata[NCH_BITS-1:0];
        REG_IDX_NORM_MODE:    norm_mode_r    <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_IDX_NUM_CHANNELS: cfg_prdata = CFG_DATA_BITS'(num_channels_r);
      REG_IDX_NORM_MODE:    cfg_prdata = CFG_DATA_BITS'(norm_mode_r);
      default:              cfg_prdata = '0;
    endcase
  end

  phl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .score        (in_tdata[SCORE_BITS-1:0]),
    .class_label  (in_tdata[SCORE_BITS+LABEL_BITS-1:SCORE_BITS]),
    .last_channel (in_tlast),
    .end_of_batch (in_tuser),
    .num_channels (num_channels_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_elem       (q_in)
  );

  phl_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  phl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  phl_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .norm_mode      (norm_mode_r),
    .q_empty        (q_empty),
    .q_elem         (q_out),
    .q_pop          (q_pop),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .result_kind    (result_kind),
    .hinge_value    (hinge_value),
    .gradient_value (gradient_value),
    .mean_loss      (mean_loss),
    .valid_pixels   (valid_pixels),
    .correct_pixels (correct_pixels),
    .last           (out_tlast)
  );

  // Pack the result fields, lowest field first
  assign out_tuser = result_kind;
  assign out_tdata = {6'b0, correct_pixels, valid_pixels, mean_loss,
                      gradient_value, hinge_value};

`ifndef NO_ASSERTIONS
  // A batch summary always closes the results of its batch
  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_SUMMARY |-> out_tlast)
    else $error("batch summary without last");

  // A zero hinge never carries a gradient
  a_zero_grad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ELEM && out_tdata[15:0] == '0
    |-> out_tdata[33:16] == '0)
    else $error("gradient on zero hinge");

  // Correct pixels never exceed valid pixels in a summary
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_SUMMARY
    |-> out_tdata[145:114] <= out_tdata[113:82])
    else $error("correct count above valid count");
`endif

endmodule
